// ===== rtl/mif_pkg.sv =====
// ----------------------------------------------------------------------------
// mif_pkg
// Shared types and constants of the motion integrator with fade.
// ----------------------------------------------------------------------------
package mif_pkg;

   localparam int IMG_W      = 640;
   localparam int IMG_H      = 480;
   localparam int PIX_DEPTH  = IMG_W * IMG_H;
   localparam int ADDR_W     = $clog2(PIX_DEPTH);

   localparam int PIX_W      = 8;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 9;
   localparam int MODE_W     = 2;
   localparam int ACC_W      = 16;
   localparam int TAG_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;
   localparam int RAD_W      = 8;
   localparam int PHASE_W    = 8;

   // signed width of the clipped exclusion bounds
   localparam int EXC_W = $clog2((IMG_W > IMG_H ? IMG_W : IMG_H) + 1024) + 2;

   localparam logic [TAG_W-1:0] TAG_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FADE_PERIOD    = 3'd0,
      CSR_FADE_DISABLE   = 3'd1,
      CSR_EXCLUDE_X      = 3'd2,
      CSR_EXCLUDE_Y      = 3'd3,
      CSR_EXCLUDE_RADIUS = 3'd4,
      CSR_ERASE_X        = 3'd5,
      CSR_ERASE_Y        = 3'd6,
      CSR_ERASE_RADIUS   = 3'd7
   } csr_index_type;

   typedef enum logic {
      ST_SWEEP,
      ST_RUN
   } sweep_state_type;

   typedef struct packed {
      logic fade;
      logic erase_post;
      logic erase_pre;
      logic reset_frame;
   } frame_flags_type;

   // one store entry: previous pixel, running sum, epoch tag of the sum
   typedef struct packed {
      logic [PIX_W-1:0] prev;
      logic [ACC_W-1:0] acc;
      logic [TAG_W-1:0] tag;
   } word_type;

   localparam int WORD_W = $bits(word_type);

   typedef struct packed {
      frame_flags_type flags;
      logic            in_range;
      logic            tag_match;
      logic            in_erase;
      logic            in_excl;
   } upd_ctrl_type;

   typedef struct packed {
      logic [PIX_W-1:0] motion;
      logic             frame_start;
   } rsp_type;

endpackage

// ===== rtl/mif_if.sv =====
// ----------------------------------------------------------------------------
// mif_req_if / mif_rsp_if
// Pixel request channel and motion result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mif_req_if import mif_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIX_W-1:0]    pixel;
   logic [COL_W-1:0]    col;
   logic [ROW_W-1:0]    row;
   logic                frame_start;
   logic                reset_integration;
   logic [MODE_W-1:0]   erase_mode;

   modport source (output valid, pixel, col, row, frame_start, reset_integration,
                   erase_mode, input ready);
   modport sink   (input valid, pixel, col, row, frame_start, reset_integration,
                   erase_mode, output ready);
endinterface

interface mif_rsp_if import mif_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIX_W-1:0]    motion;
   logic                frame_start_out;

   modport source (output valid, motion, frame_start_out, input ready);
   modport sink   (input valid, motion, frame_start_out, output ready);
endinterface

// ===== rtl/mif_ram.sv =====
// ----------------------------------------------------------------------------
// mif_ram
// Generic single-write, single-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module mif_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/mif_update.sv =====
// ----------------------------------------------------------------------------
// mif_update
// Read-modify-write arithmetic for one pixel: erase, integrate, fade.
// ----------------------------------------------------------------------------
module mif_update import mif_pkg::*; (
   input  upd_ctrl_type       ctrl,
   input  logic [PIX_W-1:0]   pixel,
   input  logic [TAG_W-1:0]   tag,
   input  word_type           word_rd,
   output logic               we,
   output word_type           word_wr,
   output logic [PIX_W-1:0]   motion
);

   logic signed [ACC_W+1:0] sum;
   logic signed [ACC_W-1:0] acc_sat;
   logic signed [ACC_W-1:0] acc_fin;
   logic        [ACC_W-1:0] mag;

   always_comb begin
      sum = '0;
      if (ctrl.tag_match && !(ctrl.flags.erase_pre && ctrl.in_erase)) begin
         sum = (ACC_W+2)'(signed'(word_rd.acc));
      end
      sum = sum + signed'((ACC_W+2)'(pixel)) - signed'((ACC_W+2)'(word_rd.prev));
      if (sum > (ACC_W+2)'(32767)) begin
         acc_sat = 16'sh7fff;
      end else if (sum < -(ACC_W+2)'(32768)) begin
         acc_sat = 16'sh8000;
      end else begin
         acc_sat = sum[ACC_W-1:0];
      end
      acc_fin = acc_sat;
      if (ctrl.flags.fade && !ctrl.in_excl) begin
         if (acc_sat > 0) begin
            acc_fin = acc_sat - 16'sd1;
         end else if (acc_sat < 0) begin
            acc_fin = acc_sat + 16'sd1;
         end
      end
      if (ctrl.flags.erase_post && ctrl.in_erase) begin
         acc_fin = '0;
      end
      // -32768 negates to 16'h8000, which still reads as a large unsigned magnitude
      mag = acc_fin[ACC_W-1] ? ACC_W'(-acc_fin) : ACC_W'(acc_fin);

      we           = ctrl.in_range;
      word_wr.prev = pixel;
      word_wr.tag  = tag;
      if (ctrl.flags.reset_frame) begin
         word_wr.acc = '0;
         motion      = '0;
      end else begin
         word_wr.acc = acc_fin;
         motion      = (mag > ACC_W'(255)) ? 8'hff : mag[PIX_W-1:0];
      end
      if (!ctrl.in_range) begin
         motion = '0;
      end
   end

endmodule

// ===== rtl/mif_out_fifo.sv =====
// ----------------------------------------------------------------------------
// mif_out_fifo
// Two-entry result buffer that decouples the pipeline from the receiver.
// ----------------------------------------------------------------------------
module mif_out_fifo import mif_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rsp_type    push_data,
   output logic [1:0] count,
   output logic       pop,
   mif_rsp_if.source  rsp_ch
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign pop                    = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.valid           = (count_ff != 2'd0);
   assign rsp_ch.motion          = entry_ff[rd_ptr_ff].motion;
   assign rsp_ch.frame_start_out = entry_ff[rd_ptr_ff].frame_start;
   assign count                  = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/motion_integrator_with_fade.sv =====
// ----------------------------------------------------------------------------
// motion_integrator_with_fade
// Per-pixel frame-difference integrator with periodic fade and erase circle.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one pixel beat (pixel, col, row, frame_start and the frame
//   settings sampled on frame_start). rsp_ch returns one beat per request:
//   motion = min(|sum|, 255) and the frame_start echo, in request order.
//   csr_we/csr_index/csr_wdata write the eight settings; write them idle.
// Pipeline: a beat passes the stage 1 registers and then the result buffer
//   before it reaches rsp_ch. Throughput: one pixel per cycle while req_ch.ready
//   is high, set by the single read and single write port of the store; the stored
//   word of the previous beat is forwarded when the next beat hits the same pixel.
// Reset frames clear all sums by bumping an epoch tag kept with every entry;
//   entries of an older epoch read as zero. When the tag would wrap, and once
//   after reset, a clearing pass over all IMG_W*IMG_H entries rewrites the
//   store while req_ch.ready stays low.
// Stall: a two-entry result buffer lets requests flow while a result waits;
//   when it fills, req_ch.ready drops and the pipeline holds nothing extra.
// ----------------------------------------------------------------------------
module motion_integrator_with_fade import mif_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mif_req_if.sink               req_ch,
   mif_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // settings
   logic [PHASE_W-1:0] fade_period_ff;
   logic               fade_disable_ff;
   logic [COL_W-1:0]   exclude_x_ff;
   logic [ROW_W-1:0]   exclude_y_ff;
   logic [RAD_W-1:0]   exclude_radius_ff;
   logic [COL_W-1:0]   erase_x_ff;
   logic [ROW_W-1:0]   erase_y_ff;
   logic [RAD_W-1:0]   erase_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_period_ff    <= '0;
         fade_disable_ff   <= 1'b0;
         exclude_x_ff      <= '0;
         exclude_y_ff      <= '0;
         exclude_radius_ff <= '0;
         erase_x_ff        <= '0;
         erase_y_ff        <= '0;
         erase_radius_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FADE_PERIOD:    fade_period_ff    <= csr_wdata[PHASE_W-1:0];
            CSR_FADE_DISABLE:   fade_disable_ff   <= csr_wdata[0];
            CSR_EXCLUDE_X:      exclude_x_ff      <= csr_wdata[COL_W-1:0];
            CSR_EXCLUDE_Y:      exclude_y_ff      <= csr_wdata[ROW_W-1:0];
            CSR_EXCLUDE_RADIUS: exclude_radius_ff <= csr_wdata[RAD_W-1:0];
            CSR_ERASE_X:        erase_x_ff        <= csr_wdata[COL_W-1:0];
            CSR_ERASE_Y:        erase_y_ff        <= csr_wdata[ROW_W-1:0];
            CSR_ERASE_RADIUS:   erase_radius_ff   <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // derived geometry, refreshed every cycle from the settings
   logic signed [EXC_W-1:0] ex_x0, ex_y0, ex_w, ex_h;
   logic signed [EXC_W-1:0] ex_x0_ff, ex_y0_ff, ex_x1_ff, ex_y1_ff;
   logic                    ex_en_ff;
   logic [2*RAD_W-1:0]      rr2_ff;

   always_comb begin
      ex_x0 = signed'(EXC_W'(exclude_x_ff)) - signed'(EXC_W'(exclude_radius_ff));
      ex_y0 = signed'(EXC_W'(exclude_y_ff)) - signed'(EXC_W'(exclude_radius_ff));
      if (ex_x0 < 0) begin
         ex_x0 = '0;
      end
      if (ex_y0 < 0) begin
         ex_y0 = '0;
      end
      ex_w = signed'(EXC_W'({exclude_radius_ff, 1'b0}));
      ex_h = ex_w;
      if (ex_w + ex_x0 >= signed'(EXC_W'(IMG_W))) begin
         ex_w = signed'(EXC_W'(IMG_W - 1)) - ex_x0;
      end
      if (ex_h + ex_y0 >= signed'(EXC_W'(IMG_H))) begin
         ex_h = signed'(EXC_W'(IMG_H - 1)) - ex_y0;
      end
   end

   always_ff @(posedge clock) begin
      ex_x0_ff <= ex_x0;
      ex_y0_ff <= ex_y0;
      ex_x1_ff <= ex_x0 + ex_w;
      ex_y1_ff <= ex_y0 + ex_h;
      ex_en_ff <= (exclude_x_ff != '0) && (ex_w > 0) && (ex_h > 0);
      rr2_ff   <= erase_radius_ff * erase_radius_ff;
   end

   // frame control
   frame_flags_type    flags_ff, flags_in, beat_flags;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TAG_W-1:0]   epoch_ff, epoch_in;
   logic               rst_start;
   logic               req_accept;

   assign rst_start = req_ch.frame_start &&
                      (req_ch.reset_integration || (flags_ff.reset_frame && flags_ff.fade));

   always_comb begin
      flags_in = flags_ff;
      phase_in = phase_ff;
      epoch_in = epoch_ff;
      if (req_accept && req_ch.frame_start) begin
         flags_in = '0;
         if (rst_start) begin
            flags_in.reset_frame = 1'b1;
            phase_in             = '0;
            epoch_in             = epoch_ff + TAG_W'(1);
         end else begin
            flags_in.fade       = (phase_ff == '0) && !fade_disable_ff;
            flags_in.erase_pre  = req_ch.erase_mode[0];
            flags_in.erase_post = req_ch.erase_mode[1];
            phase_in = (phase_ff >= fade_period_ff) ? '0 : phase_ff + PHASE_W'(1);
         end
      end
      beat_flags = flags_in;
   end

   // clearing pass
   sweep_state_type   state_ff, state_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic              s1_valid_ff;
   logic              sweep_we;
   logic              sweep_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         flags_ff      <= '{fade: 1'b1, erase_post: 1'b0, erase_pre: 1'b0, reset_frame: 1'b1};
         phase_ff      <= '0;
         epoch_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         flags_ff      <= flags_in;
         phase_ff      <= phase_in;
         // restart the epoch once every entry carries tag zero
         epoch_ff      <= sweep_done ? '0 : epoch_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_we      = 1'b0;
      sweep_done    = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            sweep_we      = 1'b1;
            sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            if (sweep_addr_ff == ADDR_W'(PIX_DEPTH - 1)) begin
               sweep_done = 1'b1;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            // tag about to wrap: drain the pipeline, then rewrite the store
            if (req_ch.valid && rst_start && (epoch_ff == TAG_MAX) && !s1_valid_ff) begin
               state_in      = ST_SWEEP;
               sweep_addr_in = '0;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   // request side
   logic [1:0] fifo_count;
   logic       fifo_pop;
   logic       room;

   assign room = ({1'b0, fifo_count} + 3'(s1_valid_ff)) < (3'd2 + 3'(fifo_pop));
   assign req_ch.ready = (state_ff == ST_RUN) && room &&
                         !(rst_start && (epoch_ff == TAG_MAX));
   assign req_accept = req_ch.valid && req_ch.ready;

   logic                    in_range;
   logic [ADDR_W-1:0]       rd_addr;
   logic signed [COL_W:0]   dx;
   logic signed [ROW_W:0]   dy;

   assign in_range = (32'(req_ch.col) < IMG_W) && (32'(req_ch.row) < IMG_H);
   assign rd_addr  = ADDR_W'(req_ch.row) * ADDR_W'(IMG_W) + ADDR_W'(req_ch.col);
   assign dx       = signed'({1'b0, req_ch.col}) - signed'({1'b0, erase_x_ff});
   assign dy       = signed'({1'b0, req_ch.row}) - signed'({1'b0, erase_y_ff});

   // stage 1 registers: hold the beat while the store answers
   logic [PIX_W-1:0]   s1_pixel_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic               s1_fs_ff;
   frame_flags_type    s1_flags_ff;
   logic [TAG_W-1:0]   s1_tag_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic               s1_range_ff;
   logic [2*COL_W-1:0] s1_dx2_ff;
   logic [2*ROW_W-1:0] s1_dy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s1_pixel_ff <= req_ch.pixel;
         s1_col_ff   <= req_ch.col;
         s1_row_ff   <= req_ch.row;
         s1_fs_ff    <= req_ch.frame_start;
         s1_flags_ff <= beat_flags;
         s1_tag_ff   <= epoch_in;
         s1_addr_ff  <= rd_addr;
         s1_range_ff <= in_range;
         s1_dx2_ff   <= (2*COL_W)'(dx * dx);
         s1_dy2_ff   <= (2*ROW_W)'(dy * dy);
      end
   end

   // store and forwarding of the latest write
   word_type          ram_rdata, word_rd, word_wr, ram_wdata;
   logic              upd_we, ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic              last_we_ff;
   logic [ADDR_W-1:0] last_addr_ff;
   word_type          last_word_ff;
   upd_ctrl_type      ctrl;
   logic [PIX_W-1:0]  motion;
   rsp_type           push_word;
   logic [2*COL_W:0]  dist2;
   logic signed [EXC_W-1:0] c_s, r_s;

   assign ram_we    = sweep_we || (s1_valid_ff && upd_we);
   assign ram_waddr = sweep_we ? sweep_addr_ff : s1_addr_ff;
   assign ram_wdata = sweep_we ? word_type'('0) : word_wr;

   mif_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PIX_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (req_accept),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         last_we_ff <= 1'b0;
      end else begin
         last_we_ff <= s1_valid_ff && upd_we && !sweep_we;
      end
      last_addr_ff <= s1_addr_ff;
      last_word_ff <= word_wr;
   end

   assign word_rd = (last_we_ff && (last_addr_ff == s1_addr_ff)) ? last_word_ff : ram_rdata;

   assign dist2 = (2*COL_W+1)'(s1_dx2_ff) + (2*COL_W+1)'(s1_dy2_ff);
   assign c_s   = signed'(EXC_W'(s1_col_ff));
   assign r_s   = signed'(EXC_W'(s1_row_ff));

   always_comb begin
      ctrl.flags     = s1_flags_ff;
      ctrl.in_range  = s1_range_ff;
      ctrl.tag_match = (word_rd.tag == s1_tag_ff);
      ctrl.in_erase  = (dist2 <= (2*COL_W+1)'(rr2_ff));
      ctrl.in_excl   = ex_en_ff && (c_s >= ex_x0_ff) && (c_s < ex_x1_ff) &&
                       (r_s >= ex_y0_ff) && (r_s < ex_y1_ff);
   end

   mif_update u_update (
      .ctrl    (ctrl),
      .pixel   (s1_pixel_ff),
      .tag     (s1_tag_ff),
      .word_rd (word_rd),
      .we      (upd_we),
      .word_wr (word_wr),
      .motion  (motion)
   );

   assign push_word.motion      = motion;
   assign push_word.frame_start = s1_fs_ff;

   mif_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (push_word),
      .count     (fifo_count),
      .pop       (fifo_pop),
      .rsp_ch    (rsp_ch)
   );

   // checks
   a_no_beat_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !req_accept)
      else $error("request beat taken during clearing pass");

   a_no_tag_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rst_start) |-> (epoch_ff != TAG_MAX))
      else $error("epoch tag wrapped without clearing pass");

   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (fifo_count == 2'd2)) |-> fifo_pop)
      else $error("result buffer overflow");

   a_sweep_pipeline_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !s1_valid_ff)
      else $error("store write collides with clearing pass");

endmodule

// ===== sim/motion_integrator_with_fade_tb.sv =====
// ----------------------------------------------------------------------------
// motion_integrator_with_fade_tb
// Self-checking bench: drives pixel beats in short frames, mostly over a small
// set of positions, predicts every motion result from its own model of the
// per-pixel stores and frame flags, and compares results in order.
// ----------------------------------------------------------------------------
module motion_integrator_with_fade_tb import mif_pkg::*; ();

   typedef struct {
      logic [PIX_W-1:0]  pixel;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              fs;
      logic              rst;
      logic [MODE_W-1:0] em;
   } pix_beat_type;

   localparam int IDLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mif_req_if req_bus ();
   mif_rsp_if rsp_bus ();

   motion_integrator_with_fade u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // pixel beats waiting to be driven, and results still owed by the block
   pix_beat_type pixel_q[$];
   rsp_type      motion_q[$];
   pix_beat_type cur_beat;
   bit        req_fire;
   int        fail_count;
   int        idle_cycles;
   int        src_idle_pct;
   int        rcv_idle_pct;
   bit        hold_req;
   bit        hold_done;
   int        hold_cnt;

   // predictor state: previous pixel, running sum and the epoch of each sum
   logic [PIX_W-1:0]        prev_mem  [PIX_DEPTH];
   logic signed [ACC_W-1:0] acc_mem   [PIX_DEPTH];
   int                      acc_epoch [PIX_DEPTH];
   int                      cur_epoch;
   logic [PHASE_W-1:0]      fade_phase;
   frame_flags_type         flags;

   // register copy
   logic [7:0] r_fade_period, r_exc_rad, r_era_rad;
   logic       r_fade_disable;
   logic [9:0] r_exc_x, r_era_x;
   logic [8:0] r_exc_y, r_era_y;

   // generator view: which previous pixels exist, and the frame kind
   bit gen_written [PIX_DEPTH];
   int written_list[$];
   bit gen_reset_frame;
   bit gen_pending;
   int pool_col[16];
   int pool_row[16];

   initial begin
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      req_bus.col = '0;
      req_bus.row = '0;
      req_bus.frame_start = 1'b0;
      req_bus.reset_integration = 1'b0;
      req_bus.erase_mode = '0;
      rsp_bus.ready = 1'b0;
   end

   function automatic bit in_erase(int c, int r);
      int dx, dy, rr;
      dx = c - int'(r_era_x);
      dy = r - int'(r_era_y);
      rr = int'(r_era_rad);
      return dx * dx + dy * dy <= rr * rr;
   endfunction

   function automatic bit in_exclusion(int c, int r);
      int rad, x0, y0, w, h;
      if (r_exc_x == 0) return 1'b0;
      rad = int'(r_exc_rad);
      x0 = int'(r_exc_x) - rad;
      y0 = int'(r_exc_y) - rad;
      w = 2 * rad;
      h = 2 * rad;
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (w + x0 >= IMG_W) w = IMG_W - x0 - 1;
      if (h + y0 >= IMG_H) h = IMG_H - y0 - 1;
      if (w <= 0 || h <= 0) return 1'b0;
      return c >= x0 && c < x0 + w && r >= y0 && r < y0 + h;
   endfunction

   // advance the model by one pixel beat and return the motion it yields
   function automatic rsp_type integrate_pixel(pix_beat_type b);
      rsp_type res;
      int c, r, idx, a;
      c = int'(b.col);
      r = int'(b.row);
      res.motion = '0;
      res.frame_start = b.fs;
      if (b.fs) begin
         if (b.rst || (flags.reset_frame && flags.fade)) begin
            flags = '0;
            flags.reset_frame = 1'b1;
            cur_epoch++;
            fade_phase = '0;
         end else begin
            flags = '0;
            flags.fade = (fade_phase == 0) && !r_fade_disable;
            fade_phase = (fade_phase >= r_fade_period) ? '0 : fade_phase + 1'b1;
            flags.erase_pre = b.em[0];
            flags.erase_post = b.em[1];
         end
      end
      if (c < IMG_W && r < IMG_H) begin
         idx = r * IMG_W + c;
         if (flags.reset_frame) begin
            prev_mem[idx] = b.pixel;
            acc_mem[idx] = '0;
            acc_epoch[idx] = cur_epoch;
         end else begin
            a = (acc_epoch[idx] == cur_epoch) ? int'(acc_mem[idx]) : 0;
            if (flags.erase_pre && in_erase(c, r)) a = 0;
            a = a + int'(b.pixel) - int'(prev_mem[idx]);
            if (a > 32767) a = 32767;
            if (a < -32768) a = -32768;
            prev_mem[idx] = b.pixel;
            if (flags.fade && !in_exclusion(c, r)) begin
               if (a > 0) a--;
               else if (a < 0) a++;
            end
            if (flags.erase_post && in_erase(c, r)) a = 0;
            acc_mem[idx] = a[ACC_W-1:0];
            acc_epoch[idx] = cur_epoch;
            if (a < 0) a = -a;
            res.motion = (a > 255) ? 8'd255 : a[7:0];
         end
      end
      return res;
   endfunction

   task automatic flag_mismatch(string what);
      $display("error @%0t: %s", $realtime, what);
      fail_count++;
   endtask

   // accept beats, predict, check; also watch for a stuck run
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset) begin
         req_fire = req_bus.valid && req_bus.ready;
         if (req_fire) motion_q.insert(motion_q.size(), integrate_pixel(cur_beat));
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.motion = rsp_bus.motion;
            got.frame_start = rsp_bus.frame_start_out;
            if (motion_q.size() == 0) begin
               flag_mismatch("result beat with nothing expected");
            end else begin
               want = motion_q.pop_front();
               if (got.motion !== want.motion)
                  flag_mismatch($sformatf("motion %0d, want %0d", got.motion, want.motion));
               if (got.frame_start !== want.frame_start)
                  flag_mismatch($sformatf("frame_start_out %0b, want %0b",
                                          got.frame_start, want.frame_start));
            end
         end
         if (req_fire || (rsp_bus.valid && rsp_bus.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("motion_integrator_with_fade: mismatch");
            $finish;
         end
      end
   end

   // sender: offer the next beat once the current one is taken
   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || req_fire)) begin
         if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
            cur_beat = pixel_q.pop_front();
            req_bus.pixel <= cur_beat.pixel;
            req_bus.col <= cur_beat.col;
            req_bus.row <= cur_beat.row;
            req_bus.frame_start <= cur_beat.fs;
            req_bus.reset_integration <= cur_beat.rst;
            req_bus.erase_mode <= cur_beat.em;
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold to back up the pipeline
   always @(negedge clock) begin
      if (hold_req && !hold_done) begin
         hold_cnt = 400;
         hold_done = 1'b1;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_FADE_PERIOD:    r_fade_period = v[7:0];
         CSR_FADE_DISABLE:   r_fade_disable = v[0];
         CSR_EXCLUDE_X:      r_exc_x = v[9:0];
         CSR_EXCLUDE_Y:      r_exc_y = v[8:0];
         CSR_EXCLUDE_RADIUS: r_exc_rad = v[7:0];
         CSR_ERASE_X:        r_era_x = v[9:0];
         CSR_ERASE_Y:        r_era_y = v[8:0];
         CSR_ERASE_RADIUS:   r_era_rad = v[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(int fp, int fd, int ex, int ey, int er, int cx, int cy, int cr);
      csr_write(CSR_FADE_PERIOD, CSR_DATA_W'(fp));
      csr_write(CSR_FADE_DISABLE, CSR_DATA_W'(fd));
      csr_write(CSR_EXCLUDE_X, CSR_DATA_W'(ex));
      csr_write(CSR_EXCLUDE_Y, CSR_DATA_W'(ey));
      csr_write(CSR_EXCLUDE_RADIUS, CSR_DATA_W'(er));
      csr_write(CSR_ERASE_X, CSR_DATA_W'(cx));
      csr_write(CSR_ERASE_Y, CSR_DATA_W'(cy));
      csr_write(CSR_ERASE_RADIUS, CSR_DATA_W'(cr));
   endtask

   // queue one beat; track the frame kind so no unwritten previous pixel is read
   task automatic push_pixel(int pix, int c, int r, bit fs, bit rst, int em);
      pix_beat_type b;
      int idx, pick;
      if (fs) begin
         gen_reset_frame = rst || gen_pending;
         gen_pending = 1'b0;
      end
      if (c < IMG_W && r < IMG_H) begin
         idx = r * IMG_W + c;
         if (gen_reset_frame) begin
            if (!gen_written[idx]) written_list.insert(written_list.size(), idx);
            gen_written[idx] = 1'b1;
         end else if (!gen_written[idx]) begin
            if (written_list.size() > 0) begin
               pick = written_list[$urandom_range(written_list.size() - 1)];
               c = pick % IMG_W;
               r = pick / IMG_W;
            end else begin
               c = 1023;
            end
         end
      end
      b.pixel = PIX_W'(pix);
      b.col = COL_W'(c);
      b.row = ROW_W'(r);
      b.fs = fs;
      b.rst = rst;
      b.em = MODE_W'(em);
      pixel_q.insert(pixel_q.size(), b);
   endtask

   function automatic int near(int center, int span, int lim);
      int v;
      v = center + $urandom_range(2 * span) - span;
      if (v < 0) v = -v;
      if (v >= lim) v = lim - 1 - (v - lim) % lim;
      return v;
   endfunction

   function automatic int rand_pixel();
      int k;
      k = $urandom_range(9);
      if (k < 2) return 0;
      if (k < 4) return 255;
      return $urandom_range(255);
   endfunction

   // pick positions, mostly around the erase circle and exclusion square
   task automatic choose_pool();
      for (int i = 0; i < 16; i++) begin
         if (i < 8) begin
            pool_col[i] = near(r_era_x, r_era_rad + 3, IMG_W);
            pool_row[i] = near(r_era_y, r_era_rad + 3, IMG_H);
         end else if (i < 14) begin
            pool_col[i] = near(r_exc_x, r_exc_rad + 3, IMG_W);
            pool_row[i] = near(r_exc_y, r_exc_rad + 3, IMG_H);
         end else begin
            pool_col[i] = $urandom_range(IMG_W - 1);
            pool_row[i] = $urandom_range(IMG_H - 1);
         end
      end
   endtask

   task automatic rand_frame();
      int n, k, c, r, p;
      bit rst;
      rst = ($urandom_range(11) == 0);
      n = $urandom_range(3, 30);
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 70) begin
            p = $urandom_range(15);
            c = pool_col[p];
            r = pool_row[p];
         end else if (k < 85) begin
            c = near(r_era_x, r_era_rad + 2, IMG_W);
            r = near(r_era_y, r_era_rad + 2, IMG_H);
         end else if (k < 93) begin
            c = $urandom_range(IMG_W - 1);
            r = $urandom_range(IMG_H - 1);
         end else if (k < 97) begin
            c = $urandom_range(1023, IMG_W);
            r = $urandom_range(511);
         end else begin
            c = $urandom_range(1023);
            r = $urandom_range(511, IMG_H);
         end
         if (i == 0) push_pixel(rand_pixel(), c, r, 1'b1, rst, $urandom_range(3));
         else push_pixel(rand_pixel(), c, r, 1'b0, $urandom_range(1), $urandom_range(3));
      end
   endtask

   task automatic drain();
      while (pixel_q.size() > 0 || motion_q.size() > 0 || req_bus.valid)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      fail_count = 0;
      idle_cycles = 0;
      cur_epoch = 0;
      fade_phase = '0;
      flags = '0;
      flags.reset_frame = 1'b1;
      flags.fade = 1'b1;
      gen_pending = 1'b1;
      gen_reset_frame = 1'b1;
      hold_req = 1'b0;
      hold_done = 1'b0;
      hold_cnt = 0;
      src_idle_pct = 18;
      rcv_idle_pct = 66;
      r_fade_period = '0; r_fade_disable = 1'b0;
      r_exc_x = '0; r_exc_y = '0; r_exc_rad = '0;
      r_era_x = '0; r_era_y = '0; r_era_rad = '0;
      for (int i = 0; i < PIX_DEPTH; i++) begin
         acc_mem[i] = '0;
         acc_epoch[i] = 0;
         prev_mem[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: clipped exclusion at the far corner, small erase circle at the origin
      set_regs(0, 0, 639, 479, 255, 0, 0, 4);
      // pixels before any frame start count as a reset frame
      push_pixel(255, 0, 0, 1'b0, 1'b0, 0);
      push_pixel(0, 639, 479, 1'b0, 1'b0, 0);
      for (int f = 0; f < 5; f++) begin
         push_pixel(f[0] ? 255 : 0, 0, 0, 1'b1, f == 0, f % 4);
         push_pixel(f[0] ? 0 : 255, 639, 479, 1'b0, 1'b0, 0);
         push_pixel(f[0] ? 255 : 0, 3, 2, 1'b0, 1'b0, 0);
         push_pixel(255, 1023, 511, 1'b0, 1'b1, 3);
      end
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         if (ph < 3) begin
            src_idle_pct = 18; rcv_idle_pct = 66;
         end else if (ph < 6) begin
            src_idle_pct = 66; rcv_idle_pct = 18;
         end else begin
            src_idle_pct = 0; rcv_idle_pct = 0;
         end
         case (ph)
            0: set_regs(255, 1, 639, 479, 255, 639, 479, 255);
            1: set_regs(0, 0, 0, 0, 0, 320, 240, 0);
            2: set_regs(1, 0, 5, 5, 8, 600, 20, 6);
            default: set_regs($urandom_range(3), $urandom_range(1),
                              $urandom_range(639), $urandom_range(479),
                              $urandom_range(20), $urandom_range(639),
                              $urandom_range(479), $urandom_range(12));
         endcase
         choose_pool();
         while (pixel_q.size() < 172) rand_frame();
         // long receiver hold while the sender keeps offering beats
         if (ph == 1) hold_req = 1'b1;
         drain();
      end

      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("motion_integrator_with_fade: match");
      end else begin
         $display("motion_integrator_with_fade: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mif_pkg.sv
rtl/mif_if.sv
rtl/mif_ram.sv
rtl/mif_update.sv
rtl/mif_out_fifo.sv
rtl/motion_integrator_with_fade.sv
sim/motion_integrator_with_fade_tb.sv
